// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// clocked check, the expression checked in the cycle after the condition holds
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/tpcpwm_pkg.sv =====
package tpcpwm_pkg;

    localparam int LEGS       = 3;
    localparam int DUTY_LEGS  = 3;
    localparam int CNT_W      = 16;
    localparam int DLY_W      = 14;
    localparam int DUTY_W     = 16;
    localparam int FRAC_W     = 14;
    localparam int CLAMP_W    = FRAC_W + 1;
    localparam int CFG_W      = 16;

    localparam logic [CLAMP_W-1:0] DUTY_FULL    = CLAMP_W'(1 << FRAC_W);
    localparam logic [CNT_W-1:0]   PERIOD_RESET = CNT_W'(5000);
    localparam logic [CNT_W-1:0]   CMP_RESET    = CNT_W'(5000 / 2);
    localparam logic [DLY_W-1:0]   DELAY_RESET  = DLY_W'(100);

    typedef enum logic [1:0] {
        CFG_PERIOD = 2'd0,
        CFG_RISE   = 2'd1,
        CFG_FALL   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                     duty_write;
        logic signed [DUTY_W-1:0] duty_a;
        logic signed [DUTY_W-1:0] duty_b;
        logic signed [DUTY_W-1:0] duty_c;
        logic                     trip_pin;
        logic                     trip_force;
        logic                     trip_clear;
    } t_in_item;

    typedef struct packed {
        logic             gate_a_high;
        logic             gate_a_low;
        logic             gate_b_high;
        logic             gate_b_low;
        logic             gate_c_high;
        logic             gate_c_low;
        logic [CNT_W-1:0] count_value;
        logic             counting_down;
        logic             adc_trigger;
        logic             tripped;
    } t_out_item;

    // clamp a Q2.14 duty to 0..1 and scale it to compare counts
    function automatic logic [CNT_W-1:0] duty_counts(
        input logic signed [DUTY_W-1:0] duty,
        input logic [CNT_W-1:0]         period
    );
        logic [CLAMP_W-1:0]         clamp;
        logic [CLAMP_W+CNT_W-1:0]   prod;
        if (duty[DUTY_W-1]) begin
            clamp = '0;
        end else if (duty > $signed({1'b0, DUTY_FULL})) begin
            clamp = DUTY_FULL;
        end else begin
            clamp = duty[CLAMP_W-1:0];
        end
        prod = (CLAMP_W+CNT_W)'(clamp) * (CLAMP_W+CNT_W)'(period);
        return prod[FRAC_W +: CNT_W];
    endfunction

endpackage

// ===== rtl/tpcpwm_in_if.sv =====
interface tpcpwm_in_if;
    logic                 valid;
    logic                 ready;
    tpcpwm_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/tpcpwm_out_if.sv =====
interface tpcpwm_out_if;
    logic                  valid;
    logic                  ready;
    tpcpwm_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/three_phase_center_pwm_deadband_unit.sv =====
// channel   dir  handshake     payload
// i_in      in   valid/ready   duty_write, duty_a..c, trip_pin, trip_force, trip_clear
// o_out     out  valid/ready   six gates, count_value, counting_down, adc_trigger, tripped
// i_cfg_*   in   write enable  register index, 16-bit data
//
// one tick per cycle unless o_out stalls; a transferred tick waits in the input register,
// then its result is held in the result register, which drives o_out
// the duty scaling multiply and the compare/dead-band update share the one stage
// synchronous active-low reset; the trip latch comes out of reset set
// a stalled output holds its result while one more tick waits in the input register
`include "assert_macros.svh"

module three_phase_center_pwm_deadband_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tpcpwm_in_if.sink                     i_in,
    tpcpwm_out_if.source                  o_out,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [tpcpwm_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int LEGS  = tpcpwm_pkg::LEGS;
    localparam int CNT_W = tpcpwm_pkg::CNT_W;
    localparam int DLY_W = tpcpwm_pkg::DLY_W;

    logic [CNT_W-1:0] r_period;
    logic [DLY_W-1:0] r_rise_dly;
    logic [DLY_W-1:0] r_fall_dly;

    logic [CNT_W-1:0] r_time;
    logic             r_down;
    logic [CNT_W-1:0] r_active [LEGS];
    logic [CNT_W-1:0] r_shadow [LEGS];
    logic             r_raw    [LEGS];
    logic [DLY_W-1:0] r_rise   [LEGS];
    logic [DLY_W-1:0] r_fall   [LEGS];
    logic             r_trip;

    logic                  r_in_valid;
    tpcpwm_pkg::t_in_item  r_in;
    logic                  r_out_valid;
    tpcpwm_pkg::t_out_item r_out;

    logic [CNT_W-1:0] n_time;
    logic             n_down;
    logic [CNT_W-1:0] n_active [LEGS];
    logic [CNT_W-1:0] n_shadow [LEGS];
    logic             n_raw    [LEGS];
    logic [DLY_W-1:0] n_rise   [LEGS];
    logic [DLY_W-1:0] n_fall   [LEGS];
    logic             n_trip;
    logic             n_adc;
    logic [2*tpcpwm_pkg::DUTY_LEGS-1:0] n_gates;
    tpcpwm_pkg::t_out_item n_out;

    logic signed [tpcpwm_pkg::DUTY_W-1:0] duty_in [tpcpwm_pkg::DUTY_LEGS];
    logic             out_ready;
    logic             in_ready;
    logic             advance;

    assign out_ready   = !r_out_valid || o_out.ready;
    assign in_ready    = !r_in_valid || out_ready;
    assign advance     = r_in_valid && out_ready;
    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign duty_in[0] = r_in.duty_a;
    assign duty_in[1] = r_in.duty_b;
    assign duty_in[2] = r_in.duty_c;

    // trip latch, counter step, compare load, match, dead-band and adc trigger for one tick
    always_comb begin
        logic [CNT_W:0] up_next;
        logic           match;
        up_next = {1'b0, r_time} + (CNT_W+1)'(1);

        n_trip = r_trip;
        if (r_in.trip_clear) begin
            n_trip = 1'b0;
        end
        if (r_in.trip_pin || r_in.trip_force) begin
            n_trip = 1'b1;
        end

        n_down = r_down;
        if (!r_down) begin
            if (up_next >= {1'b0, r_period}) begin
                n_time = r_period;
                n_down = 1'b1;
            end else begin
                n_time = up_next[CNT_W-1:0];
            end
        end else begin
            if (r_time <= CNT_W'(1)) begin
                n_time = '0;
                n_down = 1'b0;
            end else begin
                n_time = r_time - CNT_W'(1);
            end
        end
        n_adc = !r_down && (n_time == r_period);

        n_gates = '0;
        for (int i = 0; i < LEGS; i++) begin
            n_shadow[i] = r_shadow[i];
            if (r_in.duty_write && i < tpcpwm_pkg::DUTY_LEGS) begin
                n_shadow[i] = tpcpwm_pkg::duty_counts(
                    duty_in[(i < tpcpwm_pkg::DUTY_LEGS) ? i : 0], r_period);
            end
            n_active[i] = (n_time == '0) ? n_shadow[i] : r_active[i];
            match       = (n_time == n_active[i]);
            n_raw[i]    = match ? n_down : r_raw[i];
            n_rise[i]   = '0;
            n_fall[i]   = '0;
            if (n_raw[i]) begin
                if (!r_raw[i]) begin
                    n_rise[i] = r_rise_dly;
                end else if (r_rise[i] != '0) begin
                    n_rise[i] = r_rise[i] - DLY_W'(1);
                end
            end else begin
                if (r_raw[i]) begin
                    n_fall[i] = r_fall_dly;
                end else if (r_fall[i] != '0) begin
                    n_fall[i] = r_fall[i] - DLY_W'(1);
                end
            end
            if (i < tpcpwm_pkg::DUTY_LEGS && !n_trip) begin
                n_gates[(i < tpcpwm_pkg::DUTY_LEGS) ? 2*i : 0] =
                    n_raw[i] && (n_rise[i] == '0);
                n_gates[(i < tpcpwm_pkg::DUTY_LEGS) ? 2*i+1 : 1] =
                    !n_raw[i] && (n_fall[i] == '0);
            end
        end

        n_out.gate_a_high   = n_gates[0];
        n_out.gate_a_low    = n_gates[1];
        n_out.gate_b_high   = n_gates[2];
        n_out.gate_b_low    = n_gates[3];
        n_out.gate_c_high   = n_gates[4];
        n_out.gate_c_low    = n_gates[5];
        n_out.count_value   = n_time;
        n_out.counting_down = n_down;
        n_out.adc_trigger   = n_adc;
        n_out.tripped       = n_trip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= tpcpwm_pkg::PERIOD_RESET;
            r_rise_dly  <= tpcpwm_pkg::DELAY_RESET;
            r_fall_dly  <= tpcpwm_pkg::DELAY_RESET;
            r_time      <= '0;
            r_down      <= 1'b0;
            r_trip      <= 1'b1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LEGS; i++) begin
                r_active[i] <= tpcpwm_pkg::CMP_RESET;
                r_shadow[i] <= tpcpwm_pkg::CMP_RESET;
                r_raw[i]    <= 1'b0;
                r_rise[i]   <= '0;
                r_fall[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tpcpwm_pkg::CFG_PERIOD: r_period   <= i_cfg_data[CNT_W-1:0];
                    tpcpwm_pkg::CFG_RISE:   r_rise_dly <= i_cfg_data[DLY_W-1:0];
                    tpcpwm_pkg::CFG_FALL:   r_fall_dly <= i_cfg_data[DLY_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_time <= n_time;
                r_down <= n_down;
                r_trip <= n_trip;
                for (int i = 0; i < LEGS; i++) begin
                    r_active[i] <= n_active[i];
                    r_shadow[i] <= n_shadow[i];
                    r_raw[i]    <= n_raw[i];
                    r_rise[i]   <= n_rise[i];
                    r_fall[i]   <= n_fall[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    `ASSERT_CLK(a_trip_gates_off, i_clk, i_rst_n,
        (r_out_valid && r_out.tripped) |-> !(r_out.gate_a_high || r_out.gate_a_low ||
        r_out.gate_b_high || r_out.gate_b_low || r_out.gate_c_high || r_out.gate_c_low),
        "gate on while tripped")
    `ASSERT_CLK(a_no_shoot_through, i_clk, i_rst_n,
        r_out_valid |-> !((r_out.gate_a_high && r_out.gate_a_low) ||
        (r_out.gate_b_high && r_out.gate_b_low) || (r_out.gate_c_high && r_out.gate_c_low)),
        "high and low gate on together")
    `ASSERT_CLK(a_adc_at_turn, i_clk, i_rst_n,
        (r_out_valid && r_out.adc_trigger) |-> r_out.counting_down,
        "adc trigger without turn to down count")
    `ASSERT_NEXT(a_stage_held, i_clk, i_rst_n, r_in_valid && !out_ready,
        r_in_valid && $stable(r_in), "input stage lost a stalled tick")

endmodule

// ===== tb/three_phase_center_pwm_deadband_unit_tb.sv =====
module three_phase_center_pwm_deadband_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpcpwm_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES = 9;

    typedef enum logic {
        ROW_TICK  = 1'b0,
        ROW_WRITE = 1'b1
    } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        t_in_item   item;
        bit         typed;
        t_out_item  want;
        t_cfg_idx   reg_idx;
        logic [15:0] reg_val;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    tpcpwm_in_if  in_if();
    tpcpwm_out_if out_if();

    three_phase_center_pwm_deadband_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic [CNT_W-1:0] period_reg = PERIOD_RESET;
    logic [DLY_W-1:0] rise_reg = DELAY_RESET;
    logic [DLY_W-1:0] fall_reg = DELAY_RESET;
    logic [CNT_W-1:0] count_now = '0;
    logic             down_now = 1'b0;
    logic [CNT_W-1:0] active_cmp [LEGS] = '{default: CMP_RESET};
    logic [CNT_W-1:0] shadow_cmp [LEGS] = '{default: CMP_RESET};
    logic             raw_now [LEGS] = '{default: 1'b0};
    logic [DLY_W-1:0] rise_left [LEGS] = '{default: '0};
    logic [DLY_W-1:0] fall_left [LEGS] = '{default: '0};
    logic             trip_now = 1'b1;

    t_out_item pending_outputs[$];
    t_out_item head_item;
    int        bad_count = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    logic [31:0] ready_pat = '0;
    int        pat_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] scale_duty(logic signed [DUTY_W-1:0] duty,
                                                   logic [CNT_W-1:0] period);
        logic [CLAMP_W-1:0] clamped;
        logic [30:0]        prod;
        if (duty < 0) begin
            clamped = '0;
        end else if (duty > 16384) begin
            clamped = 15'd16384;
        end else begin
            clamped = duty[CLAMP_W-1:0];
        end
        prod = 31'(clamped) * 31'(period);
        return prod[29:14];
    endfunction

    function automatic t_out_item advance_pwm(t_in_item it);
        t_out_item     o;
        logic [16:0]   nxt;
        logic          was_up;
        logic          old_raw;
        logic [5:0]    gates;
        int            i;
        was_up = !down_now;
        if (it.trip_clear) trip_now = 1'b0;
        if (it.trip_pin || it.trip_force) trip_now = 1'b1;
        if (it.duty_write) begin
            shadow_cmp[0] = scale_duty(it.duty_a, period_reg);
            shadow_cmp[1] = scale_duty(it.duty_b, period_reg);
            shadow_cmp[2] = scale_duty(it.duty_c, period_reg);
        end
        if (!down_now) begin
            nxt = 17'(count_now) + 17'd1;
            if (nxt >= 17'(period_reg)) begin
                nxt = 17'(period_reg);
                down_now = 1'b1;
            end
        end else if (count_now <= 1) begin
            nxt = '0;
            down_now = 1'b0;
        end else begin
            nxt = 17'(count_now) - 17'd1;
        end
        count_now = nxt[15:0];
        if (count_now == 0) active_cmp = shadow_cmp;
        gates = '0;
        for (i = 0; i < LEGS; i++) begin
            old_raw = raw_now[i];
            if (count_now == active_cmp[i]) raw_now[i] = down_now;
            if (raw_now[i]) begin
                if (!old_raw) rise_left[i] = rise_reg;
                else if (rise_left[i] > 0) rise_left[i] = rise_left[i] - 1'b1;
                fall_left[i] = '0;
            end else begin
                if (old_raw) fall_left[i] = fall_reg;
                else if (fall_left[i] > 0) fall_left[i] = fall_left[i] - 1'b1;
                rise_left[i] = '0;
            end
            if (!trip_now) begin
                gates[5 - 2 * i] = raw_now[i] && (rise_left[i] == 0);
                gates[4 - 2 * i] = !raw_now[i] && (fall_left[i] == 0);
            end
        end
        o = '0;
        {o.gate_a_high, o.gate_a_low, o.gate_b_high, o.gate_b_low,
         o.gate_c_high, o.gate_c_low} = gates;
        o.count_value = count_now;
        o.counting_down = down_now;
        o.adc_trigger = was_up && (count_now == period_reg);
        o.tripped = trip_now;
        return o;
    endfunction

    function automatic logic [5:0] gate_bits(t_out_item o);
        return {o.gate_a_high, o.gate_a_low, o.gate_b_high, o.gate_b_low,
                o.gate_c_high, o.gate_c_low};
    endfunction

    function automatic t_dir_row mk_tick(bit w, int a, int b, int c, bit pin, bit frc,
                                         bit clr);
        t_dir_row r;
        r.kind = ROW_TICK;
        r.item.duty_write = w;
        r.item.duty_a = 16'(a);
        r.item.duty_b = 16'(b);
        r.item.duty_c = 16'(c);
        r.item.trip_pin = pin;
        r.item.trip_force = frc;
        r.item.trip_clear = clr;
        r.typed = 1'b0;
        r.want = '0;
        r.reg_idx = CFG_PERIOD;
        r.reg_val = '0;
        return r;
    endfunction

    function automatic t_dir_row with_known(t_dir_row r, t_out_item want);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic t_dir_row mk_write(t_cfg_idx idx, int val);
        t_dir_row r;
        r = mk_tick(0, 0, 0, 0, 0, 0, 0);
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = 16'(val);
        return r;
    endfunction

    function automatic logic signed [DUTY_W-1:0] rand_duty();
        case ($urandom_range(0, 9))
            0: return 16'($urandom) | 16'h8000;
            1: return 16'($urandom);
            2: return 16'sd16384;
            3: return '0;
            4: return 16'($urandom_range(16385, 32767));
            default: return 16'($urandom_range(0, 16384));
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.duty_write = ($urandom_range(0, 3) == 0);
        it.duty_a = rand_duty();
        it.duty_b = rand_duty();
        it.duty_c = rand_duty();
        it.trip_pin = ($urandom_range(0, 59) == 0);
        it.trip_force = ($urandom_range(0, 79) == 0);
        it.trip_clear = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    task automatic send_tick(t_in_item it, bit typed, t_out_item want);
        t_out_item predicted;
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        burst_left--;
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data <= it;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        predicted = advance_pwm(it);
        pending_outputs.push_back(typed ? want : predicted);
    endtask

    task automatic settle_outputs();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        settle_outputs();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PERIOD: period_reg = val;
            CFG_RISE:   rise_reg = val[DLY_W-1:0];
            CFG_FALL:   fall_reg = val[DLY_W-1:0];
            default:    ;
        endcase
    endtask

    // receiver stall pattern, reloaded whenever its countdown runs out
    always @(negedge i_clk) begin
        if (pat_left == 0) begin
            pat_left = 64;
            ready_pat = ($urandom_range(0, 2) == 0) ? '1 : ($urandom | $urandom);
        end else begin
            ready_pat = {ready_pat[0], ready_pat[31:1]};
            pat_left--;
        end
        out_if.ready <= ready_pat[0];
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_outputs.size() == 0) begin
                if (bad_count < 10)
                    $display("unexpected transfer: gates %b cnt %0d", gate_bits(out_if.data),
                             out_if.data.count_value);
                bad_count++;
            end else begin
                head_item = pending_outputs.pop_front();
                if (out_if.data !== head_item) begin
                    if (bad_count < 10)
                        $display("mismatch: exp gates %b cnt %0d dn %b adc %b trip %b / got gates %b cnt %0d dn %b adc %b trip %b",
                                 gate_bits(head_item), head_item.count_value,
                                 head_item.counting_down, head_item.adc_trigger,
                                 head_item.tripped, gate_bits(out_if.data),
                                 out_if.data.count_value, out_if.data.counting_down,
                                 out_if.data.adc_trigger, out_if.data.tripped);
                    bad_count++;
                end
            end
        end
    end

    initial begin
        t_dir_row  rows[$];
        t_in_item  it;
        int        n_items;
        int        p;
        int        k;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_PERIOD;
        i_cfg_data = '0;
        i_rst_n = 1'b0;

        // reset state, trip latch set and clear
        rows.push_back(with_known(mk_tick(0, 0, 0, 0, 0, 0, 0),
                                  t_out_item'{0, 0, 0, 0, 0, 0, 16'd1, 1'b0, 1'b0, 1'b1}));
        rows.push_back(with_known(mk_tick(0, 0, 0, 0, 0, 0, 1),
                                  t_out_item'{0, 1, 0, 1, 0, 1, 16'd2, 1'b0, 1'b0, 1'b0}));
        // set wins over clear
        rows.push_back(with_known(mk_tick(0, 0, 0, 0, 1, 0, 1),
                                  t_out_item'{0, 0, 0, 0, 0, 0, 16'd3, 1'b0, 1'b0, 1'b1}));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 1, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 1));
        // clamp extremes
        rows.push_back(mk_tick(1, -32768, 32767, 0, 0, 0, 0));
        rows.push_back(mk_tick(1, 16384, 16385, -1, 0, 0, 0));
        rows.push_back(mk_tick(1, 8192, 1, 16383, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 1, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 1));
        // period lowered below the running count
        rows.push_back(mk_write(CFG_PERIOD, 3));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 1, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 1));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        // zero dead-band, full and zero duty
        rows.push_back(mk_write(CFG_RISE, 0));
        rows.push_back(mk_write(CFG_FALL, 0));
        rows.push_back(mk_tick(1, 16384, 0, 8192, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        // degenerate periods
        rows.push_back(mk_write(CFG_PERIOD, 1));
        rows.push_back(mk_tick(1, 16384, 8192, -5, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_write(CFG_PERIOD, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_WRITE)
                write_reg(rows[r].reg_idx, rows[r].reg_val);
            else
                send_tick(rows[r].item, rows[r].typed, rows[r].want);
        end

        for (p = 0; p < PHASES; p++) begin
            n_items = 200;
            case (p)
                0: begin
                    write_reg(CFG_PERIOD, 16'($urandom_range(4, 40)));
                    write_reg(CFG_RISE, 16'($urandom_range(0, 6)));
                    write_reg(CFG_FALL, 16'($urandom_range(0, 6)));
                end
                1: begin
                    write_reg(CFG_PERIOD, 16'd2);
                    write_reg(CFG_RISE, 16'd0);
                    write_reg(CFG_FALL, 16'd0);
                end
                2: begin
                    write_reg(CFG_PERIOD, 16'd65535);
                    write_reg(CFG_RISE, 16'd16383);
                    write_reg(CFG_FALL, 16'd16383);
                    n_items = 60;
                end
                3: begin
                    write_reg(CFG_PERIOD, 16'($urandom_range(20, 200)));
                    write_reg(CFG_RISE, 16'($urandom_range(0, 30)));
                    write_reg(CFG_FALL, 16'($urandom_range(0, 30)));
                end
                4: begin
                    write_reg(CFG_PERIOD, 16'd0);
                    write_reg(CFG_RISE, 16'($urandom_range(0, 3)));
                    write_reg(CFG_FALL, 16'd16383);
                end
                5: begin
                    write_reg(CFG_PERIOD, 16'd1);
                    write_reg(CFG_RISE, 16'd1);
                    write_reg(CFG_FALL, 16'd0);
                end
                6: begin
                    write_reg(CFG_PERIOD, 16'($urandom_range(2, 65535)));
                    write_reg(CFG_RISE, 16'($urandom_range(0, 16383)));
                    write_reg(CFG_FALL, 16'($urandom_range(0, 16383)));
                    n_items = 60;
                end
                7: begin
                    write_reg(CFG_PERIOD, 16'($urandom_range(3, 24)));
                    write_reg(CFG_RISE, 16'($urandom_range(0, 10)));
                    write_reg(CFG_FALL, 16'($urandom_range(0, 10)));
                end
                default: begin
                    write_reg(CFG_PERIOD, 16'($urandom_range(50, 120)));
                    write_reg(CFG_RISE, 16'($urandom_range(0, 20)));
                    write_reg(CFG_FALL, 16'($urandom_range(0, 20)));
                end
            endcase
            for (k = 0; k < n_items; k++) begin
                // hold the sender off until the output side has drained
                if (p == 0 && k == n_items / 2) settle_outputs();
                it = rand_item();
                send_tick(it, 1'b0, '0);
            end
        end

        settle_outputs();
        if (bad_count == 0 && pending_outputs.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
